// File: src/dtq_pkg.sv
// ---------------------------------------------------------------------------
// dtq_pkg: shared types and constants for the delay timer queue
// Operation and result codes, widths and controller/datapath interface.
// ---------------------------------------------------------------------------
`default_nettype none
package dtq_pkg;
  localparam int MaxWaiters = 32;
  localparam int TaskIdBits = 8;
  localparam int IdxW = $clog2(MaxWaiters);
  localparam int CntW = $clog2(MaxWaiters + 1);

  typedef enum logic [1:0] {
    OP_TICK = 2'd0, OP_QUERY = 2'd1, OP_DELAY = 2'd2, OP_UNTIL = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    K_TIME = 2'd0, K_WAKE = 2'd1, K_DONE = 2'd2, K_REJECT = 2'd3
  } kind_t;

  typedef struct packed {
    logic load;       // capture input item
    logic tick_inc;   // increment tick count
    logic rd_front;   // read entry 0
    logic rd_prev;    // read entry pos-1 (insert scan)
    logic rd_next;    // read entry pos+1 (pop shift)
    logic wr_shift_up;   // store read entry at pos, pos--
    logic wr_new;     // store new entry at pos, count++
    logic wr_shift_dn;   // store read entry at pos, pos++
    logic pop_done;   // count--
    logic ins_start;  // pos = count
    logic pop_start;  // pos = 0
  } dtq_cmd_t;

  typedef struct packed {
    op_t  op;
    logic full;
    logic empty;
    logic pos_zero;
    logic prev_gt;    // read deadline > new deadline
    logic front_due;  // read deadline <= tick count
    logic pos_end;    // pos+1 >= count
  } dtq_sts_t;
endpackage
`default_nettype wire

// File: src/dtq_datapath.sv
// ---------------------------------------------------------------------------
// dtq_datapath: tick counter, sorted waiter memory and item capture
// Holds the sorted store in a single-port-read memory with registered read.
// ---------------------------------------------------------------------------
`default_nettype none
module dtq_datapath (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire dtq_pkg::dtq_cmd_t             cmd,
  output dtq_pkg::dtq_sts_t                  sts,
  input  wire logic [1:0]                    operation,
  input  wire logic [7:0]                    task_id,
  input  wire logic [31:0]                   tick_value,
  output logic [7:0]                         item_task,
  output logic [7:0]                         rd_task,
  output logic [31:0]                        tick_count
);
  import dtq_pkg::*;

  logic [TaskIdBits+31:0] mem [MaxWaiters];
  logic [TaskIdBits+31:0] rd_data;
  logic [CntW-1:0] count;
  logic [CntW-1:0] pos;
  logic [1:0] op;
  logic [31:0] deadline;
  logic [TaskIdBits-1:0] task_r;
  logic [IdxW-1:0] rd_addr;
  logic [CntW-1:0] pos_p1;

  assign pos_p1 = pos + CntW'(1);

  always_comb begin
    rd_addr = '0;
    if (cmd.rd_prev) rd_addr = IdxW'(pos - CntW'(1));
    else if (cmd.rd_next) rd_addr = IdxW'(pos_p1);
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_front || cmd.rd_prev || cmd.rd_next) rd_data <= mem[rd_addr];
    if (cmd.wr_shift_up || cmd.wr_shift_dn) mem[IdxW'(pos)] <= rd_data;
    else if (cmd.wr_new) mem[IdxW'(pos)] <= {deadline, task_r};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count <= '0;
      count <= '0;
      pos <= '0;
    end else begin
      if (cmd.tick_inc) tick_count <= tick_count + 32'd1;
      if (cmd.ins_start) pos <= count;
      else if (cmd.pop_start) pos <= '0;
      else if (cmd.wr_shift_up) pos <= pos - CntW'(1);
      else if (cmd.wr_shift_dn) pos <= pos_p1;
      if (cmd.wr_new) count <= count + CntW'(1);
      else if (cmd.pop_done) count <= count - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op <= operation;
      task_r <= TaskIdBits'(task_id);
      deadline <= (operation == OP_DELAY) ? tick_count + tick_value : tick_value;
    end
  end

  always_comb begin
    sts.op = op_t'(op);
    sts.full = (count >= CntW'(MaxWaiters));
    sts.empty = (count == '0);
    sts.pos_zero = (pos == '0);
    sts.prev_gt = (rd_data[TaskIdBits+31:TaskIdBits] > deadline);
    sts.front_due = (rd_data[TaskIdBits+31:TaskIdBits] <= tick_count);
    sts.pos_end = (pos_p1 >= count);
  end

  assign item_task = 8'(task_r);
  assign rd_task = 8'(rd_data[TaskIdBits-1:0]);
endmodule
`default_nettype wire

// File: src/dtq_ctrl.sv
// ---------------------------------------------------------------------------
// dtq_ctrl: sequencer for the delay timer queue
// Runs insert scans, front removal and result handshakes.
// ---------------------------------------------------------------------------
`default_nettype none
module dtq_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              valid,
  output logic                   ready,
  output logic                   res_valid,
  input  wire logic              res_ready,
  output logic [1:0]             res_kind,
  output logic                   res_last,
  output logic                   res_use_rd,
  output dtq_pkg::dtq_cmd_t      cmd,
  input  wire dtq_pkg::dtq_sts_t sts
);
  import dtq_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_INS_RD, S_INS_CMP, S_POP_RD, S_POP_CHK,
    S_SHIFT_RD, S_SHIFT_WR, S_OUT
  } state_t;

  state_t state;
  logic   wake_pending;

  assign ready = (state == S_IDLE);

  always_comb begin
    cmd = '0;
    cmd.load = (state == S_IDLE) && valid;
    case (state)
      S_DECODE: begin
        if (sts.op == OP_TICK) begin
          cmd.tick_inc = 1'b1;
          cmd.pop_start = 1'b1;
        end else if ((sts.op == OP_DELAY || sts.op == OP_UNTIL) && !sts.full) begin
          cmd.ins_start = 1'b1;
        end
      end
      S_INS_RD: cmd.rd_prev = !sts.pos_zero;
      S_INS_CMP: begin
        if (sts.prev_gt && !sts.pos_zero) cmd.wr_shift_up = 1'b1;
        else cmd.wr_new = 1'b1;
      end
      S_POP_RD: begin
        cmd.rd_front = !sts.empty;
        cmd.pop_start = 1'b1;
      end
      S_SHIFT_RD: cmd.rd_next = 1'b1;
      S_SHIFT_WR: begin
        if (sts.pos_end) cmd.pop_done = 1'b1;
        else cmd.wr_shift_dn = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      res_valid <= 1'b0;
      res_kind <= K_TIME;
      res_last <= 1'b0;
      res_use_rd <= 1'b0;
      wake_pending <= 1'b0;
    end else begin
      case (state)
        S_IDLE: if (valid) state <= S_DECODE;
        S_DECODE: begin
          case (sts.op)
            OP_TICK: state <= S_POP_RD;
            OP_QUERY: begin
              res_valid <= 1'b1; res_kind <= K_TIME; res_last <= 1'b1;
              res_use_rd <= 1'b0; wake_pending <= 1'b0; state <= S_OUT;
            end
            default: begin
              if (sts.full) begin
                res_valid <= 1'b1; res_kind <= K_REJECT; res_last <= 1'b1;
                res_use_rd <= 1'b0; wake_pending <= 1'b0; state <= S_OUT;
              end else state <= S_INS_RD;
            end
          endcase
        end
        S_INS_RD: state <= sts.pos_zero ? S_INS_CMP : S_INS_CMP;
        S_INS_CMP: state <= (sts.prev_gt && !sts.pos_zero) ? S_INS_RD : S_IDLE;
        S_POP_RD: begin
          if (sts.empty) begin
            res_valid <= 1'b1; res_kind <= K_DONE; res_last <= 1'b1;
            res_use_rd <= 1'b0; wake_pending <= 1'b0; state <= S_OUT;
          end else state <= S_POP_CHK;
        end
        S_POP_CHK: begin
          if (sts.front_due) begin
            res_valid <= 1'b1; res_kind <= K_WAKE; res_last <= 1'b0;
            res_use_rd <= 1'b1; wake_pending <= 1'b1;
          end else begin
            res_valid <= 1'b1; res_kind <= K_DONE; res_last <= 1'b1;
            res_use_rd <= 1'b0; wake_pending <= 1'b0;
          end
          state <= S_OUT;
        end
        S_OUT: begin
          if (res_ready) begin
            res_valid <= 1'b0;
            state <= wake_pending ? S_SHIFT_RD : S_IDLE;
          end
        end
        S_SHIFT_RD: state <= S_SHIFT_WR;
        S_SHIFT_WR: state <= sts.pos_end ? S_POP_RD : S_SHIFT_RD;
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// File: src/delay_timer_queue.sv
// ---------------------------------------------------------------------------
// delay_timer_queue: tick counter with a sorted queue of waiting tasks
// Wakes tasks in deadline order on each tick.
// ---------------------------------------------------------------------------
// Items are taken one at a time. A query or rejected request returns its
// result through the output handshake; an insert moves each later entry up
// one place in the sorted store; a tick wakes due tasks from the front and
// removes each by shifting the later entries down, all through the single
// read port of the waiter memory. Every result waits for res_ready. No
// clearing pass after reset.
`default_nettype none
module delay_timer_queue (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        valid,
  output logic             ready,
  input  wire logic [1:0]  operation,
  input  wire logic [7:0]  task_id,
  input  wire logic [31:0] tick_value,
  output logic             res_valid,
  input  wire logic        res_ready,
  output logic [1:0]       kind,
  output logic [7:0]       task_id_res,
  output logic [31:0]      current_tick,
  output logic             last
);
  import dtq_pkg::*;

  dtq_cmd_t    cmd;
  dtq_sts_t    sts;
  logic [7:0]  item_task;
  logic [7:0]  rd_task;
  logic        use_rd;

  dtq_ctrl u_ctrl (
    .clk, .rst, .valid, .ready, .res_valid, .res_ready,
    .res_kind(kind), .res_last(last), .res_use_rd(use_rd), .cmd, .sts
  );

  dtq_datapath u_dp (
    .clk, .rst, .cmd, .sts, .operation, .task_id, .tick_value,
    .item_task, .rd_task, .tick_count(current_tick)
  );

  always_comb begin
    case (kind_t'(kind))
      K_WAKE: task_id_res = use_rd ? rd_task : item_task;
      K_DONE: task_id_res = '0;
      default: task_id_res = item_task;
    endcase
  end
endmodule
`default_nettype wire

// File: src/dtq_checker.sv
// ---------------------------------------------------------------------------
// dtq_checker: port-level checks for the delay timer queue
// ---------------------------------------------------------------------------
`default_nettype none
module dtq_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        ready,
  input wire logic        res_valid,
  input wire logic        res_ready,
  input wire logic [1:0]  kind,
  input wire logic [7:0]  task_id_res,
  input wire logic [31:0] current_tick,
  input wire logic        last
);
  import dtq_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(kind) && $stable(task_id_res)
      && $stable(current_tick) && $stable(last))
    else $error("result changed while stalled");
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(ready && res_valid)) else $error("input ready while result pending");
  a_done_last: assert property (@(posedge clk) disable iff (rst)
    res_valid && kind == K_DONE |-> last && task_id_res == 8'd0)
    else $error("tick done malformed");
  a_wake_notlast: assert property (@(posedge clk) disable iff (rst)
    res_valid && kind == K_WAKE |-> !last) else $error("wake marked last");
endmodule

bind delay_timer_queue dtq_checker u_dtq_checker (
  .clk, .rst, .ready, .res_valid, .res_ready, .kind, .task_id_res,
  .current_tick, .last
);
`default_nettype wire

// File: bench/testbench.sv
// ---------------------------------------------------------------------------
// testbench: self-checking bench for delay_timer_queue
// Drives ticks, time queries and delay requests through the input handshake
// and checks every result against a behavioral model of the sorted waiter
// store, including store-full rejections and deadline wraparound.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module testbench;
  import dtq_pkg::*;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  task_id;
    logic [31:0] tick;
    logic        last;
  } result_t;

  typedef struct packed {
    op_t         op;
    logic [7:0]  task_id;
    logic [31:0] value;
    logic        chk;
    result_t     res;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic valid = 1'b0;
  logic ready;
  logic [1:0] operation = '0;
  logic [7:0] task_id = '0;
  logic [31:0] tick_value = '0;
  logic res_valid;
  logic res_ready = 1'b0;
  logic [1:0] kind;
  logic [7:0] task_id_res;
  logic [31:0] current_tick;
  logic last;

  delay_timer_queue u_top (
    .clk(clk), .rst(rst), .valid(valid), .ready(ready),
    .operation(operation), .task_id(task_id), .tick_value(tick_value),
    .res_valid(res_valid), .res_ready(res_ready), .kind(kind),
    .task_id_res(task_id_res), .current_tick(current_tick), .last(last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // model state
  logic [31:0] now_tick;
  logic [31:0] wait_dl [$];
  logic [7:0]  wait_id [$];
  result_t     pending [$];
  result_t     typed_res [$];
  logic        typed_chk [$];
  int errors = 0;
  int n_results = 0;
  int n_wakes = 0;
  int n_rejects = 0;
  int send_idle = 0;
  int recv_idle = 0;

  function automatic result_t mk(logic [1:0] k, logic [7:0] id, logic [31:0] t, logic l);
    result_t r;
    r.kind = k;
    r.task_id = id;
    r.tick = t;
    r.last = l;
    return r;
  endfunction

  task automatic predict_queue(op_t op, logic [7:0] id, logic [31:0] val);
    logic [31:0] dl;
    int pos;
    case (op)
      OP_TICK: begin
        now_tick = now_tick + 32'd1;
        while (wait_dl.size() > 0 && wait_dl[0] <= now_tick) begin
          pending.push_back(mk(K_WAKE, wait_id[0], now_tick, 1'b0));
          void'(wait_dl.pop_front());
          void'(wait_id.pop_front());
        end
        pending.push_back(mk(K_DONE, 8'd0, now_tick, 1'b1));
      end
      OP_QUERY: pending.push_back(mk(K_TIME, id, now_tick, 1'b1));
      default: begin
        dl = (op == OP_DELAY) ? now_tick + val : val;
        if (wait_dl.size() >= MaxWaiters) begin
          pending.push_back(mk(K_REJECT, id, now_tick, 1'b1));
        end else begin
          pos = wait_dl.size();
          while (pos > 0 && wait_dl[pos-1] > dl) pos--;
          wait_dl.insert(pos, dl);
          wait_id.insert(pos, id);
        end
      end
    endcase
  endtask

  task automatic report(string what, result_t got, result_t exp);
    errors++;
    $display("MISMATCH %s: got k=%0d id=%0d t=%0d l=%0d exp k=%0d id=%0d t=%0d l=%0d",
             what, got.kind, got.task_id, got.tick, got.last,
             exp.kind, exp.task_id, exp.tick, exp.last);
  endtask

  // result side
  always @(posedge clk) begin
    result_t got, exp;
    if (!rst && res_valid && res_ready) begin
      got = mk(kind, task_id_res, current_tick, last);
      n_results++;
      if (got.kind == K_WAKE) n_wakes++;
      if (got.kind == K_REJECT) n_rejects++;
      if (pending.size() == 0) begin
        report("unexpected result", got, got);
      end else begin
        exp = pending.pop_front();
        if (got != exp) report("result", got, exp);
        if (typed_chk.size() > 0 && got.last) begin
          if (typed_chk.pop_front() && got != typed_res[0]) report("table", got, typed_res[0]);
          void'(typed_res.pop_front());
        end
      end
    end
  end

  always @(negedge clk) begin
    res_ready <= ($urandom_range(99) >= recv_idle);
  end

  // valid stays high after an item unless the sender idles or the run ends
  task automatic send(op_t op, logic [7:0] id, logic [31:0] val);
    while ($urandom_range(99) < send_idle) begin
      valid <= 1'b0;
      @(negedge clk);
    end
    operation <= op;
    task_id <= id;
    tick_value <= val;
    valid <= 1'b1;
    @(posedge clk);
    while (!ready) @(posedge clk);
    predict_queue(op, id, val);
    @(negedge clk);
  endtask

  function automatic row_t row(op_t op, logic [7:0] id, logic [31:0] v, logic c, result_t r);
    row_t x;
    x.op = op;
    x.task_id = id;
    x.value = v;
    x.chk = c;
    x.res = r;
    return x;
  endfunction

  row_t tbl [$];
  result_t nr;

  task automatic rand_item(bit deep);
    int sel;
    sel = $urandom_range(99);
    if (sel < 35) send(OP_TICK, 8'($urandom), $urandom);
    else if (sel < 45) send(OP_QUERY, 8'($urandom), $urandom);
    else if (sel < 80)
      send(OP_DELAY, 8'($urandom), deep ? $urandom : $urandom_range(6));
    else
      send(OP_UNTIL, 8'($urandom), deep ? $urandom : now_tick + $urandom_range(8));
  endtask

  initial begin
    nr = '0;
    now_tick = '0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    // directed table: check column only where the answer is obvious
    tbl.push_back(row(OP_QUERY, 8'hFF, 32'hFFFF_FFFF, 1'b1, mk(K_TIME, 8'hFF, 32'd0, 1'b1)));
    tbl.push_back(row(OP_TICK, 8'h00, 32'h0, 1'b1, mk(K_DONE, 8'h00, 32'd1, 1'b1)));
    tbl.push_back(row(OP_DELAY, 8'h11, 32'h0, 1'b0, nr));
    tbl.push_back(row(OP_DELAY, 8'h22, 32'hFFFF_FFFF, 1'b0, nr));
    tbl.push_back(row(OP_UNTIL, 8'h33, 32'h2, 1'b0, nr));
    tbl.push_back(row(OP_UNTIL, 8'h44, 32'h2, 1'b0, nr));
    tbl.push_back(row(OP_UNTIL, 8'hAA, 32'hFFFF_FFFF, 1'b0, nr));
    tbl.push_back(row(OP_UNTIL, 8'h55, 32'h0, 1'b0, nr));
    tbl.push_back(row(OP_TICK, 8'hFF, 32'hFFFF_FFFF, 1'b0, nr));
    tbl.push_back(row(OP_TICK, 8'h00, 32'h0, 1'b0, nr));
    tbl.push_back(row(OP_QUERY, 8'h00, 32'h0, 1'b1, mk(K_TIME, 8'h00, 32'd3, 1'b1)));
    for (int i = 0; i < MaxWaiters + 2; i++) begin
      if (i < 14) tbl.push_back(row(OP_UNTIL, 8'(i), 32'hFFFF_FFF0, 1'b0, nr));
    end
    foreach (tbl[i]) begin
      // only ticks and queries end in a last result here
      if (tbl[i].op == OP_TICK || tbl[i].op == OP_QUERY) begin
        typed_res.push_back(tbl[i].res);
        typed_chk.push_back(tbl[i].chk);
      end
      send(tbl[i].op, tbl[i].task_id, tbl[i].value);
    end
    typed_chk.delete();
    typed_res.delete();
    // fill the store to force rejections with extreme ids
    while (wait_dl.size() < MaxWaiters)
      send(OP_DELAY, 8'($urandom), $urandom_range(1000, 5000));
    send(OP_DELAY, 8'hFF, 32'h0);
    send(OP_UNTIL, 8'h00, 32'hFFFF_FFFF);
    for (int ph = 0; ph < 3; ph++) begin
      send_idle = (ph == 0) ? 22 : (ph == 1) ? 71 : 0;
      recv_idle = (ph == 0) ? 71 : (ph == 1) ? 22 : 0;
      for (int i = 0; i < 90; i++) rand_item(ph == 1 && i % 3 == 0);
      repeat (3) send(OP_TICK, 8'h00, 32'h0);
    end
    valid <= 1'b0;
    // drain: wait until every predicted result has been received
    while (pending.size() > 0) @(negedge clk);
    repeat (200) @(negedge clk);
    $display("Covered %0d results, %0d wakes, %0d rejections; final tick %0d.",
             n_results, n_wakes, n_rejects, now_tick);
    $display("Left in store: %0d tasks (deadlines far ahead).", wait_dl.size());
    if (errors == 0 && pending.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("timeout");
    $display("CHECKS FAILED");
    $finish;
  end
endmodule
`default_nettype wire
